[rtl/htl_pkg.sv]
// ----------------------------------------------------------------------------
// htl_pkg
// Shared widths, codes, state machine type and parent-unit result word
// for the hierarchical tree lock manager.
// ----------------------------------------------------------------------------
package htl_pkg;

  // field widths
  localparam int NODE_W   = 10;   // node_index
  localparam int REQ_W    = 16;   // requester_id
  localparam int BRANCH_W = 5;    // branching_factor register
  localparam int NODES_W  = 11;   // node_count register
  localparam int BELOW_W  = 11;   // locked-descendant count

  // defaults for top level parameters
  localparam int DEF_MAX_NODES  = 1024;
  localparam int DEF_OWNER_BITS = 16;

  // register reset values
  localparam logic [BRANCH_W-1:0] BRANCH_RST = 5'd2;
  localparam logic [NODES_W-1:0]  NODES_RST  = 11'd1024;

  // APB
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_BRANCH = 1'b0;
  localparam logic REG_NODES  = 1'b1;

  // request codes
  localparam logic MODE_LOCK   = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  // parent unit: quotient bits retired per cycle
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = NODE_W / DIV_STEPS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SELF_RD,
    ST_SELF_CHK,
    ST_WALK,
    ST_DIV_WAIT,
    ST_ANC_CHK,
    ST_FIN
  } state_t;

  typedef enum logic {
    PH_CHECK,
    PH_UPDATE
  } phase_t;

  typedef struct packed {
    logic              done;
    logic              has_parent;
    logic [NODE_W-1:0] parent;
  } div_res_t;

endpackage

[rtl/htl_ram.sv]
// ----------------------------------------------------------------------------
// htl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module htl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/htl_div.sv]
// ----------------------------------------------------------------------------
// htl_div
// Parent unit: divides (k-1) by the branching factor, DIV_STEPS quotient
// bits per cycle, and tells whether the sibling group of k fits below
// the node count.
// ----------------------------------------------------------------------------
module htl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [htl_pkg::NODE_W-1:0]    dividend,
  input  logic [htl_pkg::BRANCH_W-1:0]  divisor,
  input  logic [htl_pkg::NODES_W-1:0]   limit,
  output htl_pkg::div_res_t             res
);

  import htl_pkg::*;

  localparam int CYC_W = $clog2(DIV_CYCLES + 1);

  logic [CYC_W-1:0]    cnt;
  logic                done;
  logic [NODE_W-1:0]   quo, quo_next, dvd;
  logic [BRANCH_W-1:0] rem, rem_next;
  logic [BRANCH_W:0]   trial;
  logic [NODE_W+1:0]   group_end;

  // restoring division, two bits a cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {rem_next, quo_next[NODE_W-1]};
      quo_next = {quo_next[NODE_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[BRANCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CYC_W'(DIV_CYCLES);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CYC_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvd <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // q*m + m == (k-1) - r + m
  assign group_end = {2'b0, dvd} - {{(NODE_W+2-BRANCH_W){1'b0}}, rem}
                   + {{(NODE_W+2-BRANCH_W){1'b0}}, divisor};

  assign res.done       = done;
  assign res.has_parent = group_end < {{(NODE_W+2-NODES_W){1'b0}}, limit};
  assign res.parent     = quo;

endmodule

[rtl/hierarchical_tree_lock.sv]
// ----------------------------------------------------------------------------
// hierarchical_tree_lock
// Lock manager over an implicit m-ary tree with per-node lock flag, owner
// and locked-descendant count kept in RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset a clearing pass over all
// MAX_NODES entries zeroes the flag/count RAM; requests wait until it ends,
// register writes are taken throughout. A request walks the ancestor chain
// of its target node: each ancestor is visited once to check and, on a
// grant, once more to update its count, and each visit goes through walk
// control, the parent divider (steps of two quotient bits, then presenting
// the parent) and the RAM word. A chain that ends at a root other than node
// 0 costs one more parent lookup in each pass. A request refused at an
// ancestor stops at that check. An out-of-range request goes straight to
// its result, one refused at the node itself after the self read and check.
// The next request can be taken in the cycle after a result is loaded; a
// finished result waits in the output register until taken.
// ----------------------------------------------------------------------------
module hierarchical_tree_lock #(
  parameter int MAX_NODES  = htl_pkg::DEF_MAX_NODES,
  parameter int OWNER_BITS = htl_pkg::DEF_OWNER_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htl_pkg::APB_AW-1:0]    paddr,
  input  logic [htl_pkg::APB_DW-1:0]    pwdata,
  output logic [htl_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // request
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          mode,
  input  logic [htl_pkg::NODE_W-1:0]    node_index,
  input  logic [htl_pkg::REQ_W-1:0]     requester_id,
  // response
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          success
);

  import htl_pkg::*;

  localparam int AW   = $clog2(MAX_NODES);
  localparam int ST_W = 1 + BELOW_W;

  state_t state, state_next;
  phase_t phase;

  logic [BRANCH_W-1:0]   branching_factor;
  logic [NODES_W-1:0]    node_count;
  logic [BRANCH_W-1:0]   m_eff;
  logic [NODES_W-1:0]    n_eff;

  logic [AW-1:0]         clr_addr;
  logic                  mode_r;
  logic [NODE_W-1:0]     node_r;
  logic [OWNER_BITS-1:0] id_r;
  logic [NODE_W-1:0]     cur;
  logic                  ok_r;

  logic                  st_we, own_we;
  logic [AW-1:0]         st_waddr, rd_addr;
  logic [ST_W-1:0]       st_wdata, st_rdata;
  logic [OWNER_BITS-1:0] own_rdata;
  logic                  rd_flag;
  logic [BELOW_W-1:0]    rd_cnt;

  logic                  div_start;
  div_res_t              div_res;

  logic                  req_acc, in_range, self_ok, cfg_wr, rsp_free;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      branching_factor <= BRANCH_RST;
      node_count       <= NODES_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BRANCH: branching_factor <= pwdata[BRANCH_W-1:0];
        REG_NODES:  node_count       <= pwdata[NODES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BRANCH: prdata = APB_DW'(branching_factor);
      REG_NODES:  prdata = APB_DW'(node_count);
      default:    prdata = '0;
    endcase
  end

  assign m_eff = (branching_factor == '0) ? BRANCH_W'(1) : branching_factor;
  assign n_eff = (32'(node_count) > MAX_NODES) ? NODES_W'(MAX_NODES) : node_count;

  // ---------------- memories ----------------
  htl_ram #(.WIDTH(ST_W), .DEPTH(MAX_NODES)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  htl_ram #(.WIDTH(OWNER_BITS), .DEPTH(MAX_NODES)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (AW'(node_r)),
    .wdata (id_r),
    .raddr (rd_addr),
    .rdata (own_rdata)
  );

  assign rd_flag = st_rdata[ST_W-1];
  assign rd_cnt  = st_rdata[BELOW_W-1:0];

  // ---------------- parent unit ----------------
  htl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur - 1'b1),
    .divisor  (m_eff),
    .limit    (n_eff),
    .res      (div_res)
  );

  // ---------------- control ----------------
  assign req_acc  = req_valid & req_ready;
  assign in_range = {1'b0, node_index} < n_eff;
  assign rsp_free = ~rsp_valid | rsp_ready;
  assign self_ok  = (rd_cnt == '0) &&
                    ((mode_r == MODE_LOCK) ? ~rd_flag : (rd_flag && own_rdata == id_r));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_addr == AW'(MAX_NODES - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (req_valid) state_next = in_range ? ST_SELF_RD : ST_FIN;
      ST_SELF_RD:  state_next = ST_SELF_CHK;
      ST_SELF_CHK: state_next = self_ok ? ST_WALK : ST_FIN;
      ST_WALK: begin
        if (cur != '0)               state_next = ST_DIV_WAIT;
        else if (phase == PH_UPDATE) state_next = ST_FIN;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) state_next = div_res.has_parent ? ST_ANC_CHK : ST_WALK;
      end
      ST_ANC_CHK:  state_next = (phase == PH_CHECK && rd_flag) ? ST_FIN : ST_WALK;
      ST_FIN:      if (rsp_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    div_start = 1'b0;
    st_we     = 1'b0;
    own_we    = 1'b0;
    st_waddr  = AW'(cur);
    st_wdata  = '0;
    rd_addr   = AW'(node_r);
    unique case (state)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_addr;
      end
      ST_IDLE:  req_ready = 1'b1;
      ST_WALK: begin
        if (cur != '0) begin
          div_start = 1'b1;
        end else if (phase == PH_CHECK) begin
          // all ancestors free: commit the node itself
          st_we    = 1'b1;
          st_waddr = AW'(node_r);
          st_wdata = {(mode_r == MODE_LOCK), BELOW_W'(0)};
          own_we   = (mode_r == MODE_LOCK);
        end
      end
      ST_DIV_WAIT: rd_addr = AW'(div_res.parent);
      ST_ANC_CHK: begin
        if (phase == PH_UPDATE) begin
          st_we    = 1'b1;
          st_wdata = {rd_flag, (mode_r == MODE_LOCK) ? rd_cnt + 1'b1 : rd_cnt - 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_FIN && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          mode_r <= mode;
          node_r <= node_index;
          id_r   <= OWNER_BITS'(requester_id);
          ok_r   <= 1'b0;
        end
      end
      ST_SELF_CHK: begin
        cur   <= node_r;
        phase <= PH_CHECK;
      end
      ST_WALK: begin
        if (cur == '0) begin
          if (phase == PH_CHECK) begin
            phase <= PH_UPDATE;
            cur   <= node_r;
          end else begin
            ok_r <= 1'b1;
          end
        end
      end
      ST_DIV_WAIT: begin
        // a root ends the walk: cur back to zero
        if (div_res.done) begin
          cur <= div_res.has_parent ? div_res.parent : '0;
        end
      end
      ST_FIN: begin
        if (rsp_free) begin
          success <= ok_r;
        end
      end
      default: ;
    endcase
  end

endmodule

[test/hierarchical_tree_lock_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hierarchical_tree_lock_tb
// Self-checking bench for the tree lock manager. Requests are queued per
// phase and driven with random gaps, responses are taken with random
// stalls (except in one steady phase), and a local copy of the lock tree
// predicts every grant. The tree shape is changed over the APB port between
// phases, including once while locks are still held.
// ----------------------------------------------------------------------------
module hierarchical_tree_lock_tb;
  import htl_pkg::*;

  localparam int          MAX_NODES   = DEF_MAX_NODES;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [APB_AW-1:0] ADDR_BRANCH = {REG_BRANCH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_NODES  = {REG_NODES, 2'b00};

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] node;
    logic [REQ_W-1:0]  who;
  } lock_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic              mode = MODE_LOCK;
  logic [NODE_W-1:0] node_index = '0;
  logic [REQ_W-1:0]  requester_id = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic              success;

  hierarchical_tree_lock dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .mode         (mode),
    .node_index   (node_index),
    .requester_id (requester_id),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .success      (success)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // local copy of the lock tree
  logic               held      [MAX_NODES];
  logic [REQ_W-1:0]   holder    [MAX_NODES];
  logic [BELOW_W-1:0] below_cnt [MAX_NODES];
  logic [BRANCH_W-1:0] branch_reg;
  logic [NODES_W-1:0]  nodes_reg;

  lock_req_t   req_pending[$];
  logic        granted_q[$];
  lock_req_t   next_req;
  logic        req_fire = 1'b0;
  logic        want_ok;
  logic        steady = 1'b0;
  int          errors = 0;
  int unsigned cycles = 0;

  function automatic int unsigned eff_nodes();
    return (32'(nodes_reg) > MAX_NODES) ? MAX_NODES : 32'(nodes_reg);
  endfunction

  // parent exists only when the whole sibling group fits below the count
  function automatic bit parent_of_node(input int unsigned k, output int unsigned p);
    int unsigned m, q;
    m = (branch_reg == 0) ? 1 : 32'(branch_reg);
    if (k == 0) return 1'b0;
    q = (k - 1) / m;
    if (q * m + m >= eff_nodes()) return 1'b0;
    p = q;
    return 1'b1;
  endfunction

  function automatic bit subtree_free(input int unsigned k);
    int unsigned cur, p;
    if (below_cnt[k] != 0) return 1'b0;
    cur = k;
    while (parent_of_node(cur, p)) begin
      if (held[p]) return 1'b0;
      cur = p;
    end
    return 1'b1;
  endfunction

  function automatic void shift_counts(input int unsigned k, input bit up);
    int unsigned cur, p;
    cur = k;
    while (parent_of_node(cur, p)) begin
      below_cnt[p] = up ? below_cnt[p] + 1'b1 : below_cnt[p] - 1'b1;
      cur = p;
    end
  endfunction

  function automatic logic apply_request(input lock_req_t r);
    int unsigned k;
    k = 32'(r.node);
    if (k >= eff_nodes()) return 1'b0;
    if (r.mode == MODE_LOCK) begin
      if (held[k] || !subtree_free(k)) return 1'b0;
      held[k]   = 1'b1;
      holder[k] = r.who;
      shift_counts(k, 1'b1);
    end else begin
      if (!held[k] || !subtree_free(k) || holder[k] != r.who) return 1'b0;
      held[k] = 1'b0;
      shift_counts(k, 1'b0);
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // request side: predict on acceptance
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && req_ready;
    if (!rst && req_valid && req_ready)
      granted_q = {granted_q, apply_request({mode, node_index, requester_id})};
  end

  always @(negedge clk) begin
    if (!rst && (!req_valid || req_fire)) begin
      if (req_pending.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
        next_req = req_pending.pop_front();
        req_valid    <= 1'b1;
        mode         <= next_req.mode;
        node_index   <= next_req.node;
        requester_id <= next_req.who;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_ready <= steady || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (granted_q.size() == 0) begin
        $display("%0t: response word with nothing expected, got success=%0b", $time, success);
        errors++;
      end else begin
        want_ok = granted_q.pop_front();
        if (success !== want_ok) begin
          $display("%0t: success mismatch, expected %0b, got %0b", $time, want_ok, success);
          errors++;
        end
      end
    end
  end

  task automatic push_req(input logic md, input int unsigned node, input int unsigned who);
    lock_req_t r;
    r.mode = md;
    r.node = node[NODE_W-1:0];
    r.who  = who[REQ_W-1:0];
    req_pending = {req_pending, r};
  endtask

  task automatic drain();
    do @(posedge clk);
    while (req_pending.size() != 0 || req_valid || granted_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    drain();
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == REG_BRANCH) ? ADDR_BRANCH : ADDR_NODES;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BRANCH) branch_reg = value[BRANCH_W-1:0];
    else                   nodes_reg  = value[NODES_W-1:0];
  endtask

  // mostly lock / matching-unlock traffic, the rest random noise
  task automatic traffic(input int count);
    int unsigned owned[$];
    int unsigned n, k, r;
    int          left;
    left = count;
    while (left > 0) begin
      drain();
      n = eff_nodes();
      owned.delete();
      for (int i = 0; i < n; i++)
        if (held[i]) owned = {owned, 32'(i)};
      for (int j = 0; j < 10 && left > 0; j++, left--) begin
        r = $urandom_range(99);
        if (n == 0 || r < 15) begin
          push_req(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(65535));
        end else if (r < 55 || owned.size() == 0) begin
          push_req(MODE_LOCK, $urandom_range(n - 1), $urandom_range(3));
        end else begin
          k = owned[$urandom_range(owned.size() - 1)];
          if ($urandom_range(99) < 85) push_req(MODE_UNLOCK, k, 32'(holder[k]));
          else push_req(MODE_UNLOCK, k, 32'(holder[k] ^ (16'h1 << $urandom_range(15))));
        end
      end
    end
  endtask

  task automatic release_all();
    drain();
    for (int i = 0; i < eff_nodes(); i++)
      if (held[i]) push_req(MODE_UNLOCK, i, 32'(holder[i]));
    drain();
  endtask

  initial begin
    for (int i = 0; i < MAX_NODES; i++) begin
      held[i]      = 1'b0;
      holder[i]    = '0;
      below_cnt[i] = '0;
    end
    branch_reg = BRANCH_RST;
    nodes_reg  = NODES_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default binary tree over 1024 nodes
    push_req(MODE_LOCK,   0,    16'hFFFF);
    push_req(MODE_LOCK,   1023, 16'h0001);   // a root: its sibling group passes the node count
    push_req(MODE_UNLOCK, 0,    16'h7FFF);   // wrong owner
    push_req(MODE_UNLOCK, 0,    16'hFFFF);
    push_req(MODE_LOCK,   1023, 16'h0000);
    push_req(MODE_LOCK,   0,    16'h0000);   // granted: 1023 is not below node 0
    push_req(MODE_UNLOCK, 1023, 16'h0000);
    push_req(MODE_UNLOCK, 1023, 16'h0000);   // still held by another owner
    traffic(70);
    release_all();

    // zero branching acts as a chain, oversized count clamps to 1024
    write_reg(REG_BRANCH, 0);
    write_reg(REG_NODES, 2047);
    push_req(MODE_LOCK,   1023, 16'hA5A5);
    push_req(MODE_LOCK,   1,    16'hA5A5);
    push_req(MODE_UNLOCK, 1023, 16'hA5A5);
    write_reg(REG_BRANCH, 1);
    write_reg(REG_NODES, 20);
    traffic(60);
    release_all();

    // empty tree refuses everything
    write_reg(REG_BRANCH, 31);
    write_reg(REG_NODES, 0);
    push_req(MODE_LOCK,   0,    16'h0000);
    push_req(MODE_UNLOCK, 0,    16'h0000);
    push_req(MODE_LOCK,   1023, 16'hFFFF);

    // single node
    write_reg(REG_BRANCH, 16);
    write_reg(REG_NODES, 1);
    push_req(MODE_LOCK,   0,    16'hFFFF);
    push_req(MODE_LOCK,   1,    16'hFFFF);
    push_req(MODE_LOCK,   1023, 16'h0000);
    push_req(MODE_UNLOCK, 0,    16'h0000);
    push_req(MODE_UNLOCK, 0,    16'hFFFF);
    traffic(20);
    release_all();

    write_reg(REG_NODES, 300);
    steady = 1'b1;
    traffic(80);
    release_all();
    steady = 1'b0;

    write_reg(REG_BRANCH, 3);
    write_reg(REG_NODES, 50);
    traffic(80);
    release_all();

    write_reg(REG_BRANCH, 17);
    write_reg(REG_NODES, 1024);
    traffic(40);
    release_all();

    // reshape with locks still held; counts may wrap
    write_reg(REG_BRANCH, 2);
    write_reg(REG_NODES, 64);
    traffic(30);
    write_reg(REG_BRANCH, 4);
    write_reg(REG_NODES, 100);
    traffic(50);

    drain();
    repeat (40) @(negedge clk);
    if (granted_q.size() != 0) begin
      $display("%0t: %0d response words never arrived", $time, granted_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[hierarchical_tree_lock.f]
rtl/htl_pkg.sv
rtl/htl_ram.sv
rtl/htl_div.sv
rtl/hierarchical_tree_lock.sv
test/hierarchical_tree_lock_tb.sv
